[src/msur_pkg.sv]
package msur_pkg;

  localparam int LANE_MAX = 8;
  localparam int ECHO_W   = 5;
  localparam int IDX_W    = 3;
  localparam int DIST_W   = 14;
  localparam int TIME_W   = 32;
  localparam int PAUSE_W  = 24;
  localparam int MAXD_W   = 10;
  localparam int QUOT_W   = 15;

  localparam logic [PAUSE_W-1:0] LOW_TICKS  = 24'd2;
  localparam logic [PAUSE_W-1:0] HIGH_TICKS = 24'd10;

  // floor(8*d/29) for d below 2**16 as (8*d * ceil(2**24/29)) >> 24
  localparam int FAST_W      = 16;
  localparam int PROD_IN_W   = 19;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP = 20'd578525;

  localparam int ADDR_W = 4;
  localparam logic [ADDR_W-1:0] ADDR_ENABLE = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_MAXD   = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_PAUSE  = 4'h8;

  localparam logic [MAXD_W-1:0]  MAXD_RESET  = 10'd400;
  localparam logic [PAUSE_W-1:0] PAUSE_RESET = 24'd500000;

  typedef logic [TIME_W-1:0] tick_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH,
    PH_WAIT,
    PH_PAUSE
  } phase_t;

  typedef struct packed {
    logic [ECHO_W-1:0] trig;
    logic              rvalid;
    logic [IDX_W-1:0]  idx;
    tick_t             dur;
    logic              started;
    logic              done;
  } seq_res_t;

  typedef struct packed {
    logic [ECHO_W-1:0] trig;
    logic              rvalid;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] distance;
    logic              started;
    logic              done;
  } out_word_t;

endpackage

[src/msur_lane.sv]
module msur_lane (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           echo,
  input  msur_pkg::tick_t time_now,
  input  logic           clr,
  output logic           fin_now,
  output msur_pkg::tick_t dur_now
);
  import msur_pkg::*;

  logic  prev;
  logic  fin;
  tick_t start;
  tick_t dur;
  logic  rise;
  logic  fall;
  tick_t elapsed;

  assign rise    = echo & ~prev;
  assign fall    = ~echo & prev;
  assign elapsed = time_now - start;

  // a falling edge this tick is visible to the sequencer in the same tick
  assign fin_now = fin | fall;
  assign dur_now = fall ? elapsed : dur;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= 1'b0;
      fin  <= 1'b0;
    end else if (step) begin
      prev <= echo;
      fin  <= fin_now & ~clr;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (rise) begin
        start <= time_now;
      end
      if (fall) begin
        dur <= elapsed;
      end
    end
  end

endmodule

[src/msur_seq.sv]
module msur_seq #(
  parameter int SENSOR_COUNT = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           enable,
  input  logic [msur_pkg::PAUSE_W-1:0]   pause,
  input  logic [msur_pkg::LANE_MAX-1:0]  fin_now,
  input  msur_pkg::tick_t                dur_now [msur_pkg::LANE_MAX],
  output logic [msur_pkg::LANE_MAX-1:0]  clr,
  output msur_pkg::seq_res_t             res
);
  import msur_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSOR_COUNT - 1);

  phase_t             phase, phase_next;
  logic [PAUSE_W-1:0] cnt, cnt_next, cnt_inc;
  logic [IDX_W-1:0]   cur, cur_next;
  logic               started, started_next;
  logic [LANE_MAX-1:0] trig_wide;

  assign cnt_inc   = cnt + 1'b1;
  assign trig_wide = LANE_MAX'(1) << cur_next;

  always_comb begin
    phase_next   = phase;
    cnt_next     = cnt;
    cur_next     = cur;
    started_next = started;
    clr          = '0;
    res          = '0;
    unique case (phase)
      PH_IDLE: begin
        if (enable) begin
          cur_next   = '0;
          cnt_next   = '0;
          phase_next = PH_LOW;
        end
      end
      PH_LOW: begin
        cnt_next = cnt_inc;
        if (cnt_inc >= LOW_TICKS) begin
          cnt_next   = '0;
          phase_next = PH_HIGH;
        end
      end
      PH_HIGH: begin
        cnt_next = cnt_inc;
        if (cnt_inc >= HIGH_TICKS) begin
          cnt_next   = '0;
          phase_next = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (fin_now[cur]) begin
          clr[cur]     = 1'b1;
          started_next = 1'b1;
          res.rvalid   = 1'b1;
          res.idx      = cur;
          res.dur      = dur_now[cur];
          cnt_next     = '0;
          if (cur == LAST_IDX) begin
            res.done   = 1'b1;
            phase_next = (pause == '0) ? PH_IDLE : PH_PAUSE;
          end else begin
            cur_next   = cur + 1'b1;
            phase_next = PH_LOW;
          end
        end
      end
      PH_PAUSE: begin
        cnt_next = cnt_inc;
        if (cnt_inc >= pause) begin
          cnt_next   = '0;
          phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    res.started = started_next;
    res.trig    = (phase_next == PH_HIGH) ? trig_wide[ECHO_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      cnt     <= '0;
      cur     <= '0;
      started <= 1'b0;
    end else if (step) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      cur     <= cur_next;
      started <= started_next;
    end
  end

endmodule

[src/msur_dist.sv]
module msur_dist (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       in_pv,
  input  msur_pkg::seq_res_t         res,
  input  logic [msur_pkg::DIST_W-1:0] lim,
  output logic                       out_pv,
  output msur_pkg::out_word_t        word
);
  import msur_pkg::*;

  logic        a_pv;
  seq_res_t    a_res;
  logic [DIST_W-1:0] a_lim;

  logic        b_pv;
  seq_res_t    b_res;
  logic [DIST_W-1:0] b_lim;
  logic        b_big;
  logic [QUOT_W-1:0] b_quot;

  logic [PROD_IN_W-1:0] prod_in;
  logic [PROD_IN_W+RECIP_W-1:0] prod;

  // durations of 2**16 ticks and more are past any limit
  assign prod_in = {a_res.dur[FAST_W-1:0], 3'b000};
  assign prod    = prod_in * RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_pv <= 1'b0;
      b_pv <= 1'b0;
    end else if (adv) begin
      a_pv <= in_pv;
      b_pv <= a_pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_res  <= res;
      a_lim  <= lim;
      b_res  <= a_res;
      b_lim  <= a_lim;
      b_big  <= |a_res.dur[TIME_W-1:FAST_W];
      b_quot <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  assign out_pv = b_pv;

  always_comb begin
    word          = '0;
    word.trig     = b_res.trig;
    word.rvalid   = b_res.rvalid;
    word.idx      = b_res.idx;
    word.started  = b_res.started;
    word.done     = b_res.done;
    if (b_res.rvalid) begin
      if (b_big || (b_quot > QUOT_W'(b_lim))) begin
        word.distance = b_lim;
      end else begin
        word.distance = b_quot[DIST_W-1:0];
      end
    end
  end

endmodule

[src/multi_sensor_ultrasonic_ranger.sv]
// an accepted input word passes dist stages a and b, then the output register
// throughput: one word per cycle while s_tready is high; one result word per input tick
// stall: a two-entry output buffer holds results, s_tready drops only when both are full
// reset (rst, synchronous): sequencer idle, tick counter, echo flags and sticky
// started flag cleared, registers back to enable 1, limit 400 cm, pause 500000 ticks
module multi_sensor_ultrasonic_ranger #(
  parameter int SENSOR_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] echo_levels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [4:0] trigger_levels, [7:5] sensor_index,
                                 // [21:8] distance, [22] started
  output logic        m_tuser,   // [0] result_valid
  output logic        m_tlast,   // sweep_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [msur_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msur_pkg::*;

  logic               enable;
  logic [MAXD_W-1:0]  max_distance_cm;
  logic [PAUSE_W-1:0] sweep_pause_ticks;
  logic               cfg_wr;

  tick_t               time_counter;
  logic [LANE_MAX-1:0] echo_ext;
  logic [LANE_MAX-1:0] fin_now;
  logic [LANE_MAX-1:0] clr;
  tick_t               dur_now [LANE_MAX];
  seq_res_t            res;

  logic      adv;
  logic      acc;
  logic      pipe_pv;
  out_word_t pipe_word;
  out_word_t main_word;
  out_word_t skid_word;
  logic      skid_valid;
  logic      push;
  logic      pop;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable            <= 1'b1;
      max_distance_cm   <= MAXD_RESET;
      sweep_pause_ticks <= PAUSE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_ENABLE: enable            <= pwdata[0];
        ADDR_MAXD:   max_distance_cm   <= pwdata[MAXD_W-1:0];
        ADDR_PAUSE:  sweep_pause_ticks <= pwdata[PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_ENABLE: prdata = {31'b0, enable};
      ADDR_MAXD:   prdata = {{(32-MAXD_W){1'b0}}, max_distance_cm};
      ADDR_PAUSE:  prdata = {{(32-PAUSE_W){1'b0}}, sweep_pause_ticks};
      default:     prdata = '0;
    endcase
  end

  // input side
  assign adv      = ~skid_valid;
  assign s_tready = adv;
  assign acc      = s_tvalid & s_tready;
  assign echo_ext = {{(LANE_MAX-ECHO_W){1'b0}}, s_tdata[ECHO_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter <= '0;
    end else if (acc) begin
      time_counter <= time_counter + 1'b1;
    end
  end

  for (genvar k = 0; k < LANE_MAX; k++) begin : g_lane
    if (k < SENSOR_COUNT) begin : g_on
      msur_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .step     (acc),
        .echo     (echo_ext[k]),
        .time_now (time_counter),
        .clr      (clr[k]),
        .fin_now  (fin_now[k]),
        .dur_now  (dur_now[k])
      );
    end else begin : g_off
      assign fin_now[k] = 1'b0;
      assign dur_now[k] = '0;
    end
  end

  msur_seq #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step    (acc),
    .enable  (enable),
    .pause   (sweep_pause_ticks),
    .fin_now (fin_now),
    .dur_now (dur_now),
    .clr     (clr),
    .res     (res)
  );

  msur_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .in_pv  (acc),
    .res    (res),
    .lim    ({max_distance_cm, 4'b0000}),
    .out_pv (pipe_pv),
    .word   (pipe_word)
  );

  // output register with skid entry
  assign push = adv & pipe_pv;
  assign pop  = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (m_tvalid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_word <= skid_word;
      end
    end else if (push) begin
      if (m_tvalid && !pop) begin
        skid_word <= pipe_word;
      end else begin
        main_word <= pipe_word;
      end
    end
  end

  assign m_tdata = {1'b0, main_word.started, main_word.distance, main_word.idx,
                    main_word.trig};
  assign m_tuser = main_word.rvalid;
  assign m_tlast = main_word.done;

endmodule

[src/msur_checker.sv]
module msur_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a held word does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output word changed while stalled");

  // no report: index, distance and sweep end are zero
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[21:5] == 17'd0 && !m_tlast)
    else $error("fields set on a word without a report");

  // at most one trigger, and never on the tick of a report
  a_trig: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[4:0]) && (!m_tuser || m_tdata[4:0] == 5'd0))
    else $error("bad trigger drive");

  // a report always shows the sticky started flag
  a_started: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[22])
    else $error("report without started flag");

endmodule

bind multi_sensor_ultrasonic_ranger msur_checker u_msur_checker (.*);

[verif/tb_multi_sensor_ultrasonic_ranger.sv]
`timescale 1ns / 1ps

module tb_multi_sensor_ultrasonic_ranger;
  import msur_pkg::*;

  localparam int NSENS = 5;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [4:0] echo_levels
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;        // [4:0] trigger_levels, [7:5] sensor_index,
                                       // [21:8] distance, [22] started
  logic                m_tuser;        // [0] result_valid
  logic                m_tlast;        // sweep_done
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  multi_sensor_ultrasonic_ranger #(.SENSOR_COUNT(NSENS)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // shadow registers
  logic                cfg_enable = 1'b1;
  logic [MAXD_W-1:0]   cfg_maxd   = MAXD_RESET;
  logic [PAUSE_W-1:0]  cfg_pause  = PAUSE_RESET;

  // predicted ranger state
  logic [31:0]         tick_now = '0;
  logic [NSENS-1:0]    echo_last = '0;
  logic [31:0]         rise_time [NSENS];
  logic [31:0]         pulse_len [NSENS];
  logic [NSENS-1:0]    pulse_seen = '0;
  phase_t              seq_phase = PH_IDLE;
  int unsigned         sensor_sel = 0;
  logic [PAUSE_W-1:0]  phase_ticks = '0;
  logic                any_report = 1'b0;

  logic [4:0]          echo_queue [$];
  out_word_t           expected_reports [$];
  int                  errors = 0;
  int                  cycles = 0;

  // echo pulse generator
  logic [NSENS-1:0]    gen_level = '0;
  int                  gen_left [NSENS];

  function automatic logic [DIST_W-1:0] range_of(input logic [31:0] len);
    logic [63:0] d;
    logic [63:0] lim;
    d = ({32'd0, len} * 64'd8) / 64'd29;
    lim = {54'd0, cfg_maxd} * 64'd16;
    if (d > lim) d = lim;
    return d[DIST_W-1:0];
  endfunction

  task automatic ranger_tick(input logic [4:0] echo_in);
    out_word_t w;
    logic [NSENS-1:0] echo;
    int k;
    w = '0;
    echo = echo_in[NSENS-1:0];
    for (k = 0; k < NSENS; k++) begin
      if (echo[k] && !echo_last[k]) begin
        rise_time[k] = tick_now;
      end else if (!echo[k] && echo_last[k]) begin
        pulse_len[k] = tick_now - rise_time[k];
        pulse_seen[k] = 1'b1;
      end
    end
    echo_last = echo;
    tick_now = tick_now + 32'd1;

    case (seq_phase)
      PH_IDLE: begin
        if (cfg_enable) begin
          sensor_sel = 0;
          phase_ticks = '0;
          seq_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        phase_ticks = phase_ticks + 1'b1;
        if (phase_ticks >= LOW_TICKS) begin
          phase_ticks = '0;
          seq_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        phase_ticks = phase_ticks + 1'b1;
        if (phase_ticks >= HIGH_TICKS) begin
          phase_ticks = '0;
          seq_phase = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (pulse_seen[sensor_sel]) begin
          pulse_seen[sensor_sel] = 1'b0;
          any_report = 1'b1;
          w.rvalid = 1'b1;
          w.idx = sensor_sel[IDX_W-1:0];
          w.distance = range_of(pulse_len[sensor_sel]);
          phase_ticks = '0;
          if (sensor_sel + 1 >= NSENS) begin
            w.done = 1'b1;
            seq_phase = (cfg_pause == '0) ? PH_IDLE : PH_PAUSE;
          end else begin
            sensor_sel = sensor_sel + 1;
            seq_phase = PH_LOW;
          end
        end
      end
      PH_PAUSE: begin
        phase_ticks = phase_ticks + 1'b1;
        if (phase_ticks >= cfg_pause) begin
          phase_ticks = '0;
          seq_phase = PH_IDLE;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase

    w.trig = (seq_phase == PH_HIGH) ? (5'd1 << sensor_sel) : 5'd0;
    w.started = any_report;
    expected_reports.push_back(w);
  endtask

  // driver
  int  s_gap = 0;
  logic s_calm = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      if (s_tvalid && s_tready) ranger_tick(s_tdata[4:0]);
      if (!s_tvalid || s_tready) begin
        if (s_gap > 0) begin
          s_gap--;
          s_tvalid <= 1'b0;
        end else if (echo_queue.size() > 0) begin
          s_tdata <= {3'b000, echo_queue.pop_front()};
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) s_calm = ~s_calm;
          s_gap = s_calm ? 0 : $urandom_range(0, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  m_stall = 0;
  logic m_calm = 1'b0;
  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected word on master side: tdata %h", m_tdata);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          if (m_tdata[4:0] !== want.trig) begin
            $error("trigger_levels: expected %0d, got %0d", want.trig, m_tdata[4:0]);
            errors++;
          end
          if (m_tuser !== want.rvalid) begin
            $error("result_valid: expected %0d, got %0d", want.rvalid, m_tuser);
            errors++;
          end
          if (m_tdata[7:5] !== want.idx) begin
            $error("sensor_index: expected %0d, got %0d", want.idx, m_tdata[7:5]);
            errors++;
          end
          if (m_tdata[21:8] !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, m_tdata[21:8]);
            errors++;
          end
          if (m_tdata[22] !== want.started) begin
            $error("started: expected %0d, got %0d", want.started, m_tdata[22]);
            errors++;
          end
          if (m_tlast !== want.done) begin
            $error("sweep_done: expected %0d, got %0d", want.done, m_tlast);
            errors++;
          end
        end
        if ($urandom_range(0, 39) == 0) m_calm = ~m_calm;
        m_stall = m_calm ? 0 : $urandom_range(0, 5);
      end
      if (m_stall > 0) begin
        m_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** multi_sensor_ultrasonic_ranger: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_ENABLE: cfg_enable = value[0];
      ADDR_MAXD:   cfg_maxd = value[MAXD_W-1:0];
      ADDR_PAUSE:  cfg_pause = value[PAUSE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic reg_check(input logic [ADDR_W-1:0] addr, input logic [31:0] want);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("register %0h: expected %0d, got %0d", addr, want, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(input logic en, input logic [MAXD_W-1:0] maxd,
                          input logic [PAUSE_W-1:0] pause);
    reg_write(ADDR_ENABLE, {31'd0, en});
    reg_write(ADDR_MAXD, {22'd0, maxd});
    reg_write(ADDR_PAUSE, {8'd0, pause});
    reg_check(ADDR_ENABLE, {31'd0, cfg_enable});
    reg_check(ADDR_MAXD, {22'd0, cfg_maxd});
    reg_check(ADDR_PAUSE, {8'd0, cfg_pause});
  endtask

  task automatic drain();
    while (echo_queue.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly clean echo pulses per sensor, with some noise words mixed in
  task automatic queue_pulses(input int count);
    int n;
    int k;
    for (n = 0; n < count; n++) begin
      for (k = 0; k < NSENS; k++) begin
        if (gen_left[k] <= 0) begin
          gen_level[k] = ~gen_level[k];
          gen_left[k] = gen_level[k] ? $urandom_range(1, 60) : $urandom_range(1, 25);
        end else begin
          gen_left[k]--;
        end
      end
      if ($urandom_range(0, 9) == 0) echo_queue.push_back(5'($urandom_range(0, 31)));
      else echo_queue.push_back(gen_level);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < NSENS; i++) begin
      rise_time[i] = '0;
      pulse_len[i] = '0;
      gen_left[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    reg_check(ADDR_ENABLE, 32'd1);
    reg_check(ADDR_MAXD, {22'd0, MAXD_RESET});
    reg_check(ADDR_PAUSE, {8'd0, PAUSE_RESET});

    // zero pause: back to idle right after the last sensor
    set_regs(1'b1, 10'd1023, 24'd0);
    echo_queue.push_back(5'd0);
    echo_queue.push_back(5'd0);
    repeat (3) echo_queue.push_back(5'd31);
    echo_queue.push_back(5'd0);
    echo_queue.push_back(5'd31);
    echo_queue.push_back(5'd0);
    for (i = 0; i < NSENS; i++) echo_queue.push_back(5'd1 << i);
    echo_queue.push_back(5'd0);
    repeat (6) echo_queue.push_back(5'd31);
    echo_queue.push_back(5'd0);
    echo_queue.push_back(5'd21);
    echo_queue.push_back(5'd10);
    echo_queue.push_back(5'd0);
    queue_pulses(140);
    drain();

    // limit of 1 cm: the longest echoes saturate
    set_regs(1'b1, 10'd1, 24'd5);
    queue_pulses(90);
    drain();

    // disabled: a sweep underway still completes, then the sequencer parks
    set_regs(1'b0, 10'd1, 24'd5);
    queue_pulses(40);
    drain();

    // longest pause, then shortened while the sequencer is pausing
    set_regs(1'b1, 10'd600, 24'hFFFFFF);
    queue_pulses(100);
    drain();
    set_regs(1'b1, 10'd37, 24'd3);
    queue_pulses(90);
    drain();

    if (errors == 0) begin
      $display("** multi_sensor_ultrasonic_ranger: PASSED **");
    end else begin
      $display("** multi_sensor_ultrasonic_ranger: FAILED **");
    end
    $finish;
  end

endmodule

[multi_sensor_ultrasonic_ranger.f]
src/msur_pkg.sv
src/msur_lane.sv
src/msur_seq.sv
src/msur_dist.sv
src/multi_sensor_ultrasonic_ranger.sv
src/msur_checker.sv
verif/tb_multi_sensor_ultrasonic_ranger.sv
